>>> src/ccrl_pkg.sv
// ----------------------------------------------------------------------------
// ccrl_pkg
// Shared types and constants of the character class range lookup block:
// field widths, item kinds, command opcodes and register indexes.
// ----------------------------------------------------------------------------
package ccrl_pkg;

  // field widths
  localparam int CODE_W  = 21;
  localparam int CLASS_W = 8;
  localparam int SLOT_W  = 8;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 9;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register indexes, taken from paddr[2]
  localparam logic REG_DEFAULT_CLASS = 1'b0;
  localparam logic REG_RANGE_COUNT   = 1'b1;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_DIRECT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_RANGE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP      = 2'd2;

  // commands handed from the front to the back
  typedef enum logic [1:0] {
    OP_LOAD_DIRECT = 2'd0,
    OP_LOAD_RANGE  = 2'd1,
    OP_LOOK_DIRECT = 2'd2,
    OP_LOOK_RANGE  = 2'd3
  } ccrl_op_t;

  typedef struct packed {
    ccrl_op_t            op;
    logic [SLOT_W-1:0]   slot;
    logic [CODE_W-1:0]   range_first;
    logic [CODE_W-1:0]   range_last;
    logic [CLASS_W-1:0]  class_value;
    logic [CODE_W-1:0]   code;
  } ccrl_cmd_t;

  // register values seen by the back
  typedef struct packed {
    logic [CLASS_W-1:0] default_class;
    logic [COUNT_W-1:0] range_count;
  } ccrl_cfg_t;

endpackage

>>> src/ccrl_ifs.sv
// ----------------------------------------------------------------------------
// ccrl channel interfaces
// Valid/ready channels for input items and lookup results.
// ----------------------------------------------------------------------------
interface ccrl_item_if;
  logic                          valid;
  logic                          ready;
  logic [ccrl_pkg::KIND_W-1:0]   kind;
  logic [ccrl_pkg::SLOT_W-1:0]   slot;
  logic [ccrl_pkg::CODE_W-1:0]   range_low;
  logic [ccrl_pkg::CODE_W-1:0]   range_high;
  logic [ccrl_pkg::CLASS_W-1:0]  class_value;
  logic [ccrl_pkg::CODE_W-1:0]   code;

  modport source (
    output valid, kind, slot, range_low, range_high, class_value, code,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, range_low, range_high, class_value, code,
    output ready
  );
endinterface

interface ccrl_result_if;
  logic                          valid;
  logic                          ready;
  logic [ccrl_pkg::CLASS_W-1:0]  class_out;
  logic                          used_default;

  modport source (output valid, class_out, used_default, input ready);
  modport sink (input valid, class_out, used_default, output ready);
endinterface

>>> src/ccrl_front.sv
// ----------------------------------------------------------------------------
// ccrl_front
// Accepts input items, turns them into commands and queues them in a
// two-entry fifo. Items that change nothing are accepted and dropped.
// ----------------------------------------------------------------------------
module ccrl_front #(
  parameter int RANGE_DEPTH = 256,
  parameter int DIRECT_SIZE = 128
) (
  input  logic                clk,
  input  logic                rst,
  ccrl_item_if.sink           item,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output ccrl_pkg::ccrl_cmd_t cmd
);

  ccrl_pkg::ccrl_cmd_t cls;
  logic                keep;
  logic                push;
  logic                pop;
  logic [1:0]          count;
  logic                wr_ptr;
  logic                rd_ptr;
  ccrl_pkg::ccrl_cmd_t q_mem [2];

  // classify the incoming item
  always_comb begin
    keep            = 1'b0;
    cls.op          = ccrl_pkg::OP_LOOK_RANGE;
    cls.slot        = item.slot;
    cls.range_last  = item.range_high;
    cls.class_value = item.class_value;
    cls.code        = item.code;
    // a first bound inside the direct span starts at the end of that span
    if (32'(item.range_low) < 32'(DIRECT_SIZE)) begin
      cls.range_first = ccrl_pkg::CODE_W'(DIRECT_SIZE);
    end else begin
      cls.range_first = item.range_low;
    end
    case (item.kind)
      ccrl_pkg::KIND_LOAD_DIRECT: begin
        cls.op = ccrl_pkg::OP_LOAD_DIRECT;
        keep   = 32'(item.slot) < 32'(DIRECT_SIZE);
      end
      ccrl_pkg::KIND_LOAD_RANGE: begin
        cls.op = ccrl_pkg::OP_LOAD_RANGE;
        keep   = 32'(item.slot) < 32'(RANGE_DEPTH);
      end
      ccrl_pkg::KIND_LOOKUP: begin
        keep = 1'b1;
        if (32'(item.code) < 32'(DIRECT_SIZE)) begin
          cls.op = ccrl_pkg::OP_LOOK_DIRECT;
        end else begin
          cls.op = ccrl_pkg::OP_LOOK_RANGE;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // fifo handshake
  assign item.ready = (count != 2'd2);
  assign push       = item.valid && item.ready && keep;
  assign cmd_valid  = (count != 2'd0);
  assign pop        = cmd_valid && cmd_ready;
  assign cmd        = q_mem[rd_ptr];

  // fifo pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // fifo storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
  end

endmodule

>>> src/ccrl_back.sv
// ----------------------------------------------------------------------------
// ccrl_back
// Executes queued commands: writes the direct and range tables, answers
// direct lookups and binary-searches the range table, one probe a cycle.
// ----------------------------------------------------------------------------
module ccrl_back #(
  parameter int RANGE_DEPTH = 256,
  parameter int DIRECT_SIZE = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  ccrl_pkg::ccrl_cmd_t cmd,
  input  ccrl_pkg::ccrl_cfg_t cfg,
  ccrl_result_if.source       result
);

  localparam int IDX_W = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
  localparam int CNT_W = $clog2(RANGE_DEPTH + 1);
  localparam int DIR_W = (DIRECT_SIZE > 1) ? $clog2(DIRECT_SIZE) : 1;
  localparam int SLT_W = (IDX_W > ccrl_pkg::SLOT_W) ? IDX_W : ccrl_pkg::SLOT_W;
  localparam int CMP_W = (CNT_W > ccrl_pkg::COUNT_W) ? CNT_W : ccrl_pkg::COUNT_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIRECT = 4'b0010,
    S_BOUND  = 4'b0100,
    S_PROBE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // tables
  logic [ccrl_pkg::CLASS_W-1:0] dir_mem   [DIRECT_SIZE];
  logic                         dir_valid [DIRECT_SIZE];
  logic [ccrl_pkg::CODE_W-1:0]  first_mem [RANGE_DEPTH];
  logic [ccrl_pkg::CODE_W-1:0]  last_mem  [RANGE_DEPTH];
  logic [ccrl_pkg::CLASS_W-1:0] class_mem [RANGE_DEPTH];

  logic [ccrl_pkg::CLASS_W-1:0] dir_rd;
  logic                         dir_rd_ok;
  logic [ccrl_pkg::CODE_W-1:0]  first_rd;
  logic [ccrl_pkg::CODE_W-1:0]  last_rd;
  logic [ccrl_pkg::CLASS_W-1:0] class_rd;

  logic                         dir_we;
  logic                         dir_re;
  logic                         rng_we;
  logic                         rng_re;
  logic [SLT_W-1:0]             slot_x;
  logic [IDX_W-1:0]             rng_wa;
  logic [IDX_W-1:0]             first_ra;
  logic [IDX_W-1:0]             last_ra;
  logic [DIR_W-1:0]             dir_wa;
  logic [DIR_W-1:0]             dir_ra;

  // search window, upper end held one past the last candidate
  logic [ccrl_pkg::CODE_W-1:0]  code_q;
  logic [CNT_W-1:0]             search_lo;
  logic [CNT_W-1:0]             search_hi;
  logic [IDX_W-1:0]             mid_q;
  logic [CNT_W-1:0]             lo_next;
  logic [CNT_W-1:0]             hi_next;
  logic [CNT_W:0]               mid_sum;
  logic [IDX_W-1:0]             mid_next;
  logic                         step;

  logic [CMP_W-1:0]             count_x;
  logic [CNT_W-1:0]             n_eff;
  logic [CNT_W-1:0]             n_less;
  logic                         above_last;
  logic                         below_first;
  logic                         bound_miss;
  logic                         span_ok;

  // output register
  logic                         res_valid;
  logic [ccrl_pkg::CLASS_W-1:0] res_class;
  logic                         res_dflt;
  logic                         res_load;
  logic [ccrl_pkg::CLASS_W-1:0] res_class_next;
  logic                         res_dflt_next;
  logic                         out_free;

  // clamp the entry count to the table depth
  assign count_x = CMP_W'(cfg.range_count);
  assign n_eff   = (count_x > CMP_W'(RANGE_DEPTH)) ? CNT_W'(RANGE_DEPTH) : CNT_W'(count_x);
  assign n_less  = n_eff - CNT_W'(1);

  // compares against the entry just read
  assign above_last  = code_q > last_rd;
  assign below_first = code_q < first_rd;
  assign bound_miss  = (n_eff == '0) || below_first || above_last;

  // next search window
  always_comb begin
    lo_next = search_lo;
    hi_next = search_hi;
    if (state == S_BOUND) begin
      lo_next = '0;
      hi_next = n_eff;
    end else if (above_last) begin
      lo_next = CNT_W'(mid_q) + CNT_W'(1);
    end else begin
      hi_next = CNT_W'(mid_q);
    end
  end

  assign span_ok  = hi_next > lo_next;
  assign mid_sum  = {1'b0, lo_next} + {1'b0, hi_next} - (CNT_W + 1)'(1);
  assign mid_next = mid_sum[IDX_W:1];

  // read and write addresses
  assign slot_x   = SLT_W'(cmd.slot);
  assign rng_wa   = slot_x[IDX_W-1:0];
  assign dir_wa   = cmd.slot[DIR_W-1:0];
  assign dir_ra   = cmd.code[DIR_W-1:0];
  assign first_ra = (state == S_IDLE) ? '0 : mid_next;
  assign last_ra  = (state == S_IDLE) ? n_less[IDX_W-1:0] : mid_next;

  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !res_valid || result.ready;

  // sequencer
  always_comb begin
    state_next     = state;
    dir_we         = 1'b0;
    dir_re         = 1'b0;
    rng_we         = 1'b0;
    rng_re         = 1'b0;
    step           = 1'b0;
    res_load       = 1'b0;
    res_class_next = cfg.default_class;
    res_dflt_next  = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            ccrl_pkg::OP_LOAD_DIRECT: begin
              dir_we = 1'b1;
            end
            ccrl_pkg::OP_LOAD_RANGE: begin
              rng_we = 1'b1;
            end
            ccrl_pkg::OP_LOOK_DIRECT: begin
              dir_re     = 1'b1;
              state_next = S_DIRECT;
            end
            ccrl_pkg::OP_LOOK_RANGE: begin
              rng_re     = 1'b1;
              state_next = S_BOUND;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_DIRECT: begin
        if (out_free) begin
          res_load       = 1'b1;
          res_class_next = dir_rd_ok ? dir_rd : '0;
          res_dflt_next  = 1'b0;
          state_next     = S_IDLE;
        end
      end
      S_BOUND: begin
        if (!bound_miss) begin
          rng_re     = 1'b1;
          step       = 1'b1;
          state_next = S_PROBE;
        end else if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PROBE: begin
        if (!above_last && !below_first) begin
          if (out_free) begin
            res_load       = 1'b1;
            res_class_next = class_rd;
            res_dflt_next  = 1'b0;
            state_next     = S_IDLE;
          end
        end else if (span_ok) begin
          rng_re = 1'b1;
          step   = 1'b1;
        end else if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // search registers and result payload
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      code_q <= cmd.code;
    end
    if (step) begin
      search_lo <= lo_next;
      search_hi <= hi_next;
      mid_q     <= mid_next;
    end
    if (res_load) begin
      res_class <= res_class_next;
      res_dflt  <= res_dflt_next;
    end
  end

  // direct table valid bits, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIRECT_SIZE; i++) begin
        dir_valid[i] <= 1'b0;
      end
    end else if (dir_we) begin
      dir_valid[dir_wa] <= 1'b1;
    end
  end

  // direct table
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_wa] <= cmd.class_value;
    end
    if (dir_re) begin
      dir_rd    <= dir_mem[dir_ra];
      dir_rd_ok <= dir_valid[dir_ra];
    end
  end

  // range table
  always_ff @(posedge clk) begin
    if (rng_we) begin
      first_mem[rng_wa] <= cmd.range_first;
      last_mem[rng_wa]  <= cmd.range_last;
      class_mem[rng_wa] <= cmd.class_value;
    end
    if (rng_re) begin
      first_rd <= first_mem[first_ra];
      last_rd  <= last_mem[last_ra];
      class_rd <= class_mem[first_ra];
    end
  end

  assign result.valid        = res_valid;
  assign result.class_out    = res_class;
  assign result.used_default = res_dflt;

  // search window never empty while probing
  a_window_open: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (search_hi > search_lo))
    else $error("search window empty during probe");

  // probe index lies inside the window
  a_mid_inside: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (CNT_W'(mid_q) >= search_lo && CNT_W'(mid_q) < search_hi))
    else $error("probe index outside search window");

  // a result is only loaded when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_valid || result.ready))
    else $error("pending result overwritten");

  // a direct lookup goes straight to its read cycle
  a_direct_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_valid && cmd.op == ccrl_pkg::OP_LOOK_DIRECT)
      |=> (state == S_DIRECT))
    else $error("direct lookup not dispatched");

endmodule

>>> src/char_class_range_lookup.sv
// ----------------------------------------------------------------------------
// char_class_range_lookup
// Maps a character code to a class: a direct table for low codes and a
// sorted range table, binary-searched, for the rest.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  ---------+-----+------------------------------------------------------
//  item     | in  | kind, slot, range_low, range_high, class_value, code
//  result   | out | class_out, used_default (one per lookup)
//  apb      | in  | default_class at 0x0, range_count at 0x4
//
//  loads are written from idle; a direct lookup reads the direct table,
//  a range lookup reads the first and last entries, then probes the
//  table; one probe a cycle is set by the table read port
//  reset clears the queue, the sequencer, the registers and the direct
//  table valid bits at once; the range table is not cleared
//  a two-entry command queue lets items be taken while the back end searches
//  or a result waits in the output register
// ----------------------------------------------------------------------------
module char_class_range_lookup #(
  parameter int RANGE_DEPTH = 256,
  parameter int DIRECT_SIZE = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  ccrl_item_if.sink                     item,
  ccrl_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ccrl_pkg::PADDR_W-1:0]  paddr,
  input  logic [ccrl_pkg::PDATA_W-1:0]  pwdata,
  output logic [ccrl_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  ccrl_pkg::ccrl_cfg_t cfg;
  ccrl_pkg::ccrl_cmd_t cmd;
  logic                cmd_valid;
  logic                cmd_ready;
  logic                cfg_we;
  logic                reg_idx;

  // register access
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_class <= '0;
      cfg.range_count   <= '0;
    end else if (cfg_we) begin
      case (reg_idx)
        ccrl_pkg::REG_DEFAULT_CLASS: cfg.default_class <= pwdata[ccrl_pkg::CLASS_W-1:0];
        ccrl_pkg::REG_RANGE_COUNT:   cfg.range_count   <= pwdata[ccrl_pkg::COUNT_W-1:0];
        default: begin
          cfg.default_class <= cfg.default_class;
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      ccrl_pkg::REG_DEFAULT_CLASS: prdata = ccrl_pkg::PDATA_W'(cfg.default_class);
      ccrl_pkg::REG_RANGE_COUNT:   prdata = ccrl_pkg::PDATA_W'(cfg.range_count);
      default:                     prdata = '0;
    endcase
  end

  // front: accept, classify, queue
  ccrl_front #(
    .RANGE_DEPTH (RANGE_DEPTH),
    .DIRECT_SIZE (DIRECT_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // back: table writes and searches
  ccrl_back #(
    .RANGE_DEPTH (RANGE_DEPTH),
    .DIRECT_SIZE (DIRECT_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg       (cfg),
    .result    (result)
  );

endmodule

>>> dv/char_class_lookup_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_class_lookup_monitor
// Watches the item, result and register ports of the class lookup block,
// keeps its own copy of the direct and range tables, predicts the class of
// every lookup and compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module char_class_lookup_monitor #(
  parameter int RANGE_DEPTH = 256,
  parameter int DIRECT_SIZE = 128
) (
  input  logic                         clk,
  input  logic                         rst,
  ccrl_item_if                         item_mon,
  ccrl_result_if                       result_mon,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [ccrl_pkg::PADDR_W-1:0] paddr,
  input  logic [ccrl_pkg::PDATA_W-1:0] pwdata,
  output int unsigned                  fail_count,
  output int unsigned                  pending
);

  typedef struct packed {
    logic [ccrl_pkg::CLASS_W-1:0] class_out;
    logic                         used_default;
  } class_result_t;

  // shadow tables and registers
  logic [ccrl_pkg::CLASS_W-1:0] direct_cls [DIRECT_SIZE];
  logic [ccrl_pkg::CODE_W-1:0]  range_lo   [RANGE_DEPTH];
  logic [ccrl_pkg::CODE_W-1:0]  range_hi   [RANGE_DEPTH];
  logic [ccrl_pkg::CLASS_W-1:0] range_cls  [RANGE_DEPTH];
  logic [ccrl_pkg::CLASS_W-1:0] dflt_class;
  logic [ccrl_pkg::COUNT_W-1:0] range_count;

  class_result_t expected_classes [$];
  int unsigned   err_cnt = 0;

  // class of one code: direct entry, binary search over ranges, or default
  function automatic class_result_t classify_code(logic [ccrl_pkg::CODE_W-1:0] code);
    class_result_t r;
    int n;
    int lo;
    int hi;
    int mid;
    r.class_out    = dflt_class;
    r.used_default = 1'b1;
    if (code < DIRECT_SIZE) begin
      r.class_out    = direct_cls[code];
      r.used_default = 1'b0;
      return r;
    end
    n = (range_count > RANGE_DEPTH) ? RANGE_DEPTH : int'(range_count);
    if (n == 0) return r;
    lo = 0;
    hi = n - 1;
    // outside the span of the table: miss without a search
    if (code < range_lo[0] || code > range_hi[hi]) return r;
    while (hi >= lo) begin
      mid = (lo + hi) / 2;
      if (code > range_hi[mid]) lo = mid + 1;
      else if (code < range_lo[mid]) hi = mid - 1;
      else begin
        r.class_out    = range_cls[mid];
        r.used_default = 1'b0;
        return r;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    class_result_t want;
    if (rst) begin
      foreach (direct_cls[i]) direct_cls[i] = '0;
      dflt_class  = '0;
      range_count = '0;
      expected_classes.delete();
    end else begin
      // returned class against the oldest outstanding lookup
      if (result_mon.valid && result_mon.ready) begin
        if (expected_classes.size() == 0) begin
          err_cnt++;
          $error("result transaction with no lookup outstanding: class_out %0h used_default %0b",
                 result_mon.class_out, result_mon.used_default);
        end else begin
          want = expected_classes.pop_front();
          if (result_mon.class_out !== want.class_out) begin
            err_cnt++;
            $error("class_out mismatch: expected %0h, actual %0h",
                   want.class_out, result_mon.class_out);
          end
          if (result_mon.used_default !== want.used_default) begin
            err_cnt++;
            $error("used_default mismatch: expected %0b, actual %0b",
                   want.used_default, result_mon.used_default);
          end
        end
      end

      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[ccrl_pkg::PADDR_W-1] == ccrl_pkg::REG_DEFAULT_CLASS)
          dflt_class = pwdata[ccrl_pkg::CLASS_W-1:0];
        else
          range_count = pwdata[ccrl_pkg::COUNT_W-1:0];
      end

      // table loads and lookups
      if (item_mon.valid && item_mon.ready) begin
        case (item_mon.kind)
          ccrl_pkg::KIND_LOAD_DIRECT: begin
            if (item_mon.slot < DIRECT_SIZE) direct_cls[item_mon.slot] = item_mon.class_value;
          end
          ccrl_pkg::KIND_LOAD_RANGE: begin
            if (item_mon.slot < RANGE_DEPTH) begin
              // a first bound inside the direct span is raised to its end
              range_lo[item_mon.slot]  = (item_mon.range_low < DIRECT_SIZE) ?
                                         ccrl_pkg::CODE_W'(DIRECT_SIZE) : item_mon.range_low;
              range_hi[item_mon.slot]  = item_mon.range_high;
              range_cls[item_mon.slot] = item_mon.class_value;
            end
          end
          ccrl_pkg::KIND_LOOKUP: expected_classes.push_back(classify_code(item_mon.code));
          default: ;
        endcase
      end
    end
    fail_count <= err_cnt;
    pending    <= expected_classes.size();
  end

endmodule

>>> dv/char_class_range_lookup_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_class_range_lookup_tb
// Drives the class lookup block with directed cases and then phases of
// random range tables and lookups, with random gaps on both channels and
// one long result stall, and reports the verdict of the monitor.
// ----------------------------------------------------------------------------
module char_class_range_lookup_tb;

  localparam int CLK_PERIOD     = 10;
  localparam int RANGE_DEPTH    = 256;
  localparam int DIRECT_SIZE    = 128;
  localparam int CODE_MAX       = 1114111;
  localparam int KIND_W         = ccrl_pkg::KIND_W;
  localparam int SLOT_W         = ccrl_pkg::SLOT_W;
  localparam int CODE_W         = ccrl_pkg::CODE_W;
  localparam int CLASS_W        = ccrl_pkg::CLASS_W;
  localparam int COUNT_W        = ccrl_pkg::COUNT_W;
  localparam int PADDR_W        = ccrl_pkg::PADDR_W;
  localparam int PDATA_W        = ccrl_pkg::PDATA_W;
  localparam int COUNT_MAX      = (1 << COUNT_W) - 1;
  localparam int ITEM_TARGET    = 1800;
  localparam int SETTLE_CYCLES  = 24;
  localparam int LONG_HOLD      = 250;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [KIND_W-1:0]  KIND_UNUSED        = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_DEFAULT_CLASS = {ccrl_pkg::REG_DEFAULT_CLASS, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_RANGE_COUNT   = {ccrl_pkg::REG_RANGE_COUNT, 2'b00};

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [CODE_W-1:0]  range_low;
    logic [CODE_W-1:0]  range_high;
    logic [CLASS_W-1:0] class_value;
    logic [CODE_W-1:0]  code;
  } class_item_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ccrl_item_if   item_if ();
  ccrl_result_if result_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent_items;
  int unsigned table_size;
  bit          no_idle;
  bit          long_hold_req;

  // bounds as sent, used to aim lookups at the loaded ranges and to reload existing ranges
  logic [CODE_W-1:0] shadow_lo [RANGE_DEPTH];
  logic [CODE_W-1:0] shadow_hi [RANGE_DEPTH];

  char_class_range_lookup #(
    .RANGE_DEPTH (RANGE_DEPTH),
    .DIRECT_SIZE (DIRECT_SIZE)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  char_class_lookup_monitor #(
    .RANGE_DEPTH (RANGE_DEPTH),
    .DIRECT_SIZE (DIRECT_SIZE)
  ) u_monitor (
    .clk        (clk),
    .rst        (rst),
    .item_mon   (item_if),
    .result_mon (result_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock and reset
  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin : reset_gen
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // ends the run when no transaction of any kind moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
          (psel && penable && pwrite && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_drain
    int unsigned hold;
    result_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 6);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        result_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!(result_if.valid && result_if.ready));
    end
  end

  // one item transaction, after a random gap
  task automatic send_item(input class_item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid       <= 1'b1;
    item_if.kind        <= it.kind;
    item_if.slot        <= it.slot;
    item_if.range_low   <= it.range_low;
    item_if.range_high  <= it.range_high;
    item_if.class_value <= it.class_value;
    item_if.code        <= it.code;
    do @(posedge clk); while (!item_if.ready);
    if (it.kind == ccrl_pkg::KIND_LOAD_RANGE) begin
      shadow_lo[it.slot] = it.range_low;
      shadow_hi[it.slot] = it.range_high;
    end
    // items the block ignores do not count
    if (!(it.kind == KIND_UNUSED ||
          (it.kind == ccrl_pkg::KIND_LOAD_DIRECT && it.slot >= DIRECT_SIZE)))
      sent_items++;
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop offering, wait for every lookup to return, then let loads finish
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic class_item_t make_item(
    input logic [KIND_W-1:0]  kind,
    input logic [SLOT_W-1:0]  slot,
    input logic [CODE_W-1:0]  range_low,
    input logic [CODE_W-1:0]  range_high,
    input logic [CLASS_W-1:0] class_value,
    input logic [CODE_W-1:0]  code
  );
    class_item_t it;
    it.kind        = kind;
    it.slot        = slot;
    it.range_low   = range_low;
    it.range_high  = range_high;
    it.class_value = class_value;
    it.code        = code;
    return it;
  endfunction

  function automatic class_item_t rand_item();
    class_item_t it;
    it.kind        = KIND_W'($urandom_range(0, 3));
    it.slot        = SLOT_W'($urandom);
    it.range_low   = CODE_W'($urandom_range(0, CODE_MAX));
    it.range_high  = CODE_W'($urandom_range(0, CODE_MAX));
    it.class_value = CLASS_W'($urandom);
    it.code        = CODE_W'($urandom_range(0, CODE_MAX));
    return it;
  endfunction

  // lookup code: inside a loaded range, on its edges, direct, extreme or random
  function automatic logic [CODE_W-1:0] pick_code();
    int unsigned i;
    int c;
    c = int'($urandom_range(0, CODE_MAX));
    case ($urandom_range(0, 9)) inside
      [0:3]: begin
        if (table_size > 0) begin
          i = $urandom_range(0, table_size - 1);
          if (shadow_lo[i] <= shadow_hi[i])
            c = int'(shadow_lo[i]) + int'($urandom_range(0, shadow_hi[i] - shadow_lo[i]));
        end
      end
      4: begin
        if (table_size > 0) begin
          i = $urandom_range(0, table_size - 1);
          case ($urandom_range(0, 3))
            0:       c = int'(shadow_lo[i]) - 1;
            1:       c = int'(shadow_lo[i]);
            2:       c = int'(shadow_hi[i]);
            default: c = int'(shadow_hi[i]) + 1;
          endcase
        end
      end
      5: c = int'($urandom_range(0, DIRECT_SIZE - 1));
      6: begin
        case ($urandom_range(0, 3))
          0:       c = 0;
          1:       c = DIRECT_SIZE - 1;
          2:       c = DIRECT_SIZE;
          default: c = CODE_MAX;
        endcase
      end
      default: ;
    endcase
    if (c < 0) c = 0;
    if (c > CODE_MAX) c = CODE_MAX;
    return CODE_W'(c);
  endfunction

  // mostly lookups, with loads and the odd unused kind in between
  function automatic class_item_t traffic_item();
    class_item_t it;
    int unsigned r;
    it = rand_item();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.kind = ccrl_pkg::KIND_LOAD_DIRECT;
    end else if (r < 12) begin
      it.kind = ccrl_pkg::KIND_LOAD_RANGE;
      // usually a new class for an existing range, keeping the table sorted
      if ($urandom_range(0, 3) != 0) begin
        it.range_low  = shadow_lo[it.slot];
        it.range_high = shadow_hi[it.slot];
      end
    end else if (r < 14) begin
      it.kind = KIND_UNUSED;
    end else begin
      it.kind = ccrl_pkg::KIND_LOOKUP;
      it.code = pick_code();
    end
    return it;
  endfunction

  // sorted ranges in slots 0..n-1, with a few inverted or misplaced entries, or random bounds when scrambled
  task automatic load_table(input int unsigned n, input bit scrambled);
    class_item_t it;
    int unsigned cur;
    int unsigned span;
    int unsigned lo;
    int unsigned hi;
    int unsigned tmp;
    if (n == 0) return;
    cur  = $urandom_range(0, 300);
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64) : (CODE_MAX - 300) / n - 1;
    for (int i = 0; i < n; i++) begin
      it      = rand_item();
      it.kind = ccrl_pkg::KIND_LOAD_RANGE;
      it.slot = SLOT_W'(i);
      lo  = cur + $urandom_range(0, span / 2);
      hi  = lo + $urandom_range(0, span / 2);
      cur = hi + 1;
      if (scrambled) begin
        lo = $urandom_range(0, CODE_MAX);
        hi = $urandom_range(0, CODE_MAX);
      end else if ($urandom_range(0, 19) == 0) begin
        lo = $urandom_range(0, CODE_MAX);
      end else if ($urandom_range(0, 19) == 0) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      if (lo > CODE_MAX) lo = CODE_MAX;
      if (hi > CODE_MAX) hi = CODE_MAX;
      it.range_low  = CODE_W'(lo);
      it.range_high = CODE_W'(hi);
      send_item(it);
    end
  endtask

  initial begin : stimulus
    logic [PDATA_W-1:0] data;
    int unsigned        count_val;
    int unsigned        r;
    int unsigned        phase;
    int unsigned        traffic;
    item_if.valid       <= 1'b0;
    item_if.kind        <= ccrl_pkg::KIND_LOAD_DIRECT;
    item_if.slot        <= '0;
    item_if.range_low   <= '0;
    item_if.range_high  <= '0;
    item_if.class_value <= '0;
    item_if.code        <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    foreach (shadow_lo[i]) begin
      shadow_lo[i] = '0;
      shadow_hi[i] = '0;
    end
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    sent_items    = 0;
    table_size    = 0;
    do @(posedge clk); while (rst);

    // direct table after reset, direct loads, ignored slots, empty range table
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, 21'd0));
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, 21'd127));
    send_item(make_item(ccrl_pkg::KIND_LOAD_DIRECT, 8'd0, '0, '0, 8'hFF, '0));
    send_item(make_item(ccrl_pkg::KIND_LOAD_DIRECT, 8'd127, '0, '0, 8'h5A, '0));
    send_item(make_item(ccrl_pkg::KIND_LOAD_DIRECT, 8'd128, '0, '0, 8'h77, '0));
    send_item(make_item(ccrl_pkg::KIND_LOAD_DIRECT, 8'd255, '0, '0, 8'h77, '0));
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, 21'd0));
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, 21'd127));
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, 21'd128));
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, CODE_W'(CODE_MAX)));
    send_item(make_item(KIND_UNUSED, 8'hFF, '1, '1, 8'hFF, '1));
    // low first bound, inverted entry, entry reaching the top code
    send_item(make_item(ccrl_pkg::KIND_LOAD_RANGE, 8'd0, 21'd5, 21'd200, 8'h11, '0));
    send_item(make_item(ccrl_pkg::KIND_LOAD_RANGE, 8'd1, 21'h01000, 21'h00FFF, 8'h22, '0));
    send_item(make_item(ccrl_pkg::KIND_LOAD_RANGE, 8'd2, 21'h10FF00, CODE_W'(CODE_MAX),
                        8'hEE, '0));
    wait_idle();
    reg_write(ADDR_DEFAULT_CLASS, 32'hFF);
    reg_write(ADDR_RANGE_COUNT, 32'd3);
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, 21'd128));
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, 21'd127));
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, 21'd200));
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, 21'd201));
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, 21'h01000));
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, 21'h10FF00));
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, CODE_W'(CODE_MAX)));
    send_item(make_item(ccrl_pkg::KIND_LOOKUP, 8'd0, '0, '0, 8'h00, 21'h10FEFF));
    wait_idle();

    // random phases: new registers, a fresh table, then mixed traffic
    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      r = $urandom_range(0, 39);
      if (phase == 1) count_val = COUNT_MAX;
      else if (r == 0) count_val = $urandom_range(RANGE_DEPTH + 1, COUNT_MAX);
      else if (r == 1) count_val = RANGE_DEPTH;
      else if (r < 6) count_val = 0;
      else count_val = $urandom_range(1, 16);
      table_size = (count_val > RANGE_DEPTH) ? RANGE_DEPTH : count_val;

      data = $urandom;
      case ($urandom_range(0, 3))
        0:       data[CLASS_W-1:0] = '0;
        1:       data[CLASS_W-1:0] = '1;
        default: ;
      endcase
      reg_write(ADDR_DEFAULT_CLASS, data);
      data = $urandom;
      data[COUNT_W-1:0] = COUNT_W'(count_val);
      reg_write(ADDR_RANGE_COUNT, data);

      no_idle = ($urandom_range(0, 4) == 0);
      load_table(table_size, $urandom_range(0, 9) == 0);

      // one phase holds off results long enough to back up the input
      traffic = $urandom_range(10, 60);
      if (phase == 3) begin
        no_idle       = 1'b1;
        long_hold_req = 1'b1;
        traffic       = 60;
      end
      repeat (traffic) send_item(traffic_item());
      wait_idle();
      phase++;
    end

    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
